[rtl/ising_diagonal_energy_scale_assert.svh]
// Assertion macros used by the checker file of the Ising energy block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ISING_DIAGONAL_ENERGY_SCALE_ASSERT_SVH
`define ISING_DIAGONAL_ENERGY_SCALE_ASSERT_SVH

// Clocked property, disabled while the active-low reset is low.
`define IDES_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication built on the macro above.
`define IDES_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    `IDES_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication built on the first macro.
`define IDES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `IDES_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

[rtl/ides_pkg.sv]
// Shared types and constants of the diagonal Ising energy block.
// No dependencies; imported by every module of the block.
package ides_pkg;

    localparam int N_SPINS    = 16;
    localparam int SPIN_W     = $clog2(N_SPINS);
    localparam int COUP_DEPTH = N_SPINS * N_SPINS;
    localparam int COUP_AW    = $clog2(COUP_DEPTH);
    localparam int N_TERMS    = N_SPINS * (N_SPINS + 1) / 2;

    localparam int COEF_W  = 16;
    localparam int BASIS_W = 16;
    localparam int AMP_W   = 16;
    localparam int SCALE_W = 16;
    localparam int RES_W   = 24;
    localparam int ACC_W   = COEF_W + $clog2(N_TERMS);
    localparam int MUL_W   = ((ACC_W > RES_W) ? ACC_W : RES_W) + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int FRAC_SH = 15;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(32768);

    localparam logic [1:0] OP_LOAD_FIELD = 2'd0;
    localparam logic [1:0] OP_LOAD_COUP  = 2'd1;
    localparam logic [1:0] OP_EVAL       = 2'd2;

    typedef struct packed {
        logic        [1:0]         operation;
        logic        [3:0]         spin_i;
        logic        [3:0]         spin_j;
        logic signed [COEF_W-1:0]  coefficient;
        logic        [BASIS_W-1:0] basis_state;
        logic signed [AMP_W-1:0]   amp_re;
        logic signed [AMP_W-1:0]   amp_im;
    } t_in_req;

    typedef struct packed {
        logic signed [RES_W-1:0] energy;
        logic signed [RES_W-1:0] scaled_re;
        logic signed [RES_W-1:0] scaled_im;
    } t_out_res;

    // Coefficient table write port
    typedef struct packed {
        logic                     fld_we;
        logic                     coup_we;
        logic [SPIN_W-1:0]        spin_i;
        logic [SPIN_W-1:0]        spin_j;
        logic signed [COEF_W-1:0] data;
    } t_wr_req;

    // Coefficient table read port
    typedef struct packed {
        logic              is_field;
        logic [SPIN_W-1:0] spin_i;
        logic [SPIN_W-1:0] spin_j;
    } t_rd_req;

endpackage

[rtl/ising_diagonal_energy_scale.sv]
// Top level of the diagonal Ising energy block: sequencer, accumulator, I/O registers.
// Depends on ides_pkg, ides_store and ides_mac.
//
// Use: the input channel (i_in_valid / o_in_ready, payload i_in_req) carries
// requests. A field or coupling load gives no result and leaves o_in_ready high;
// a coupling load with spin_j not above spin_i and an unused operation code are
// dropped. An evaluate request walks all 16 field terms and 120 pair terms, one
// per cycle, through a single add/subtract accumulator, then runs three
// products (energy scale, real and imaginary amplitude) through one shared
// multiplier, each in a multiply state and a round state. The result goes to
// o_out_valid / o_out_res from an output register; o_in_ready stays low
// until then, so a new evaluate is not taken before the last one is done.
// The result sits in an output register: the next request is accepted while it
// waits. If the receiver still stalls when the next evaluate finishes, that
// result holds inside until the register frees.
// i_cfg_we / i_cfg_wdata write the anneal scale (Q1.15), idle only; the block does not enforce this.
// Reset clears all coefficients to zero, sets the anneal scale to 1.0 and drops
// any pending result.
module ising_diagonal_energy_scale
    import ides_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_req              i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_res             o_out_res,
    input  logic                 i_cfg_we,
    input  logic [SCALE_W-1:0]   i_cfg_wdata
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_SUM    = 10'b00_0000_0010,
        ST_DRAIN  = 10'b00_0000_0100,
        ST_MUL_E  = 10'b00_0000_1000,
        ST_RND_E  = 10'b00_0001_0000,
        ST_MUL_RE = 10'b00_0010_0000,
        ST_RND_RE = 10'b00_0100_0000,
        ST_MUL_IM = 10'b00_1000_0000,
        ST_RND_IM = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [SCALE_W-1:0]      r_scale;
    logic [SPIN_W-1:0]       r_i;
    logic [SPIN_W-1:0]       r_j;
    logic [BASIS_W-1:0]      r_basis;
    logic signed [AMP_W-1:0] r_amp_re;
    logic signed [AMP_W-1:0] r_amp_im;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_term_vld;
    logic                    r_term_add;
    logic signed [RES_W-1:0] r_energy;
    logic signed [RES_W-1:0] r_sre;
    logic signed [RES_W-1:0] r_sim;
    logic                    r_out_vld;
    t_out_res                r_out_res;

    logic                     in_fire;
    logic                     out_load;
    logic                     last_term;
    logic                     term_add;
    t_wr_req                  wr_req;
    t_rd_req                  rd_req;
    logic signed [COEF_W-1:0] rd_data;
    logic                     mac_en;
    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;
    logic signed [RES_W-1:0]  mac_rnd;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out_res;
    assign out_load    = (r_state == ST_DONE) && (!r_out_vld || i_out_ready);
    assign last_term   = (r_i == SPIN_W'(N_SPINS - 1)) && (r_j == SPIN_W'(N_SPINS - 1));

    // Loads write straight from the request
    always_comb begin
        wr_req.fld_we  = in_fire && (i_in_req.operation == OP_LOAD_FIELD);
        wr_req.coup_we = in_fire && (i_in_req.operation == OP_LOAD_COUP)
                         && (i_in_req.spin_j > i_in_req.spin_i);
        wr_req.spin_i  = SPIN_W'(i_in_req.spin_i);
        wr_req.spin_j  = SPIN_W'(i_in_req.spin_j);
        wr_req.data    = i_in_req.coefficient;
    end

    // j equal to i selects the field term of spin i
    always_comb begin
        rd_req.is_field = (r_i == r_j);
        rd_req.spin_i   = r_i;
        rd_req.spin_j   = r_j;
    end

    assign term_add = rd_req.is_field ? r_basis[r_i] : (r_basis[r_i] ^ r_basis[r_j]);

    ides_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr_req),
        .i_rd      (rd_req),
        .o_rd_data (rd_data)
    );

    always_comb begin
        mac_en = 1'b0;
        op_a   = MUL_W'(r_acc);
        op_b   = MUL_W'({1'b0, r_scale});
        case (r_state)
            ST_MUL_E: begin
                mac_en = 1'b1;
            end
            ST_MUL_RE: begin
                mac_en = 1'b1;
                op_a   = MUL_W'(r_amp_re);
                op_b   = MUL_W'(r_energy);
            end
            ST_MUL_IM: begin
                mac_en = 1'b1;
                op_a   = MUL_W'(r_amp_im);
                op_b   = MUL_W'(r_energy);
            end
            default: begin
                mac_en = 1'b0;
            end
        endcase
    end

    ides_mac u_mac (
        .i_clk  (i_clk),
        .i_en   (mac_en),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_rnd  (mac_rnd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && (i_in_req.operation == OP_EVAL)) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (last_term) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_MUL_E;
            ST_MUL_E:  n_state = ST_RND_E;
            ST_RND_E:  n_state = ST_MUL_RE;
            ST_MUL_RE: n_state = ST_RND_RE;
            ST_RND_RE: n_state = ST_MUL_IM;
            ST_MUL_IM: n_state = ST_RND_IM;
            ST_RND_IM: n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_scale    <= SCALE_RESET;
            r_out_vld  <= 1'b0;
            r_term_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_term_vld <= (r_state == ST_SUM);
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_term_add <= term_add;
        if (in_fire) begin
            r_basis  <= i_in_req.basis_state;
            r_amp_re <= i_in_req.amp_re;
            r_amp_im <= i_in_req.amp_im;
            r_i      <= '0;
            r_j      <= '0;
            r_acc    <= '0;
        end else begin
            // Advance along the upper triangle, field term first in each row
            if (r_state == ST_SUM) begin
                if (r_j == SPIN_W'(N_SPINS - 1)) begin
                    r_i <= r_i + 1'b1;
                    r_j <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (r_term_vld) begin
                if (r_term_add) begin
                    r_acc <= r_acc + ACC_W'(rd_data);
                end else begin
                    r_acc <= r_acc - ACC_W'(rd_data);
                end
            end
        end
        if (r_state == ST_RND_E) begin
            r_energy <= mac_rnd;
        end
        if (r_state == ST_RND_RE) begin
            r_sre <= mac_rnd;
        end
        if (r_state == ST_RND_IM) begin
            r_sim <= mac_rnd;
        end
        if (out_load) begin
            r_out_res.energy    <= r_energy;
            r_out_res.scaled_re <= r_sre;
            r_out_res.scaled_im <= r_sim;
        end
    end

endmodule

[rtl/ides_store.sv]
// Field coefficient registers and coupling coefficient memory with valid bits.
// Depends on ides_pkg; read data is registered, one read per cycle.
module ides_store
    import ides_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_wr_req                  i_wr,
    input  t_rd_req                  i_rd,
    output logic signed [COEF_W-1:0] o_rd_data
);

    logic signed [COEF_W-1:0] r_fld [N_SPINS];
    logic        [COEF_W-1:0] r_coup_mem [COUP_DEPTH];
    logic [COUP_DEPTH-1:0]    r_coup_vld;

    logic signed [COEF_W-1:0] r_fld_q;
    logic        [COEF_W-1:0] r_coup_q;
    logic                     r_coup_q_vld;
    logic                     r_is_field;

    logic [COUP_AW-1:0] wr_addr;
    logic [COUP_AW-1:0] rd_addr;

    assign wr_addr = COUP_AW'(COUP_AW'(i_wr.spin_i) * COUP_AW'(N_SPINS) + COUP_AW'(i_wr.spin_j));
    assign rd_addr = COUP_AW'(COUP_AW'(i_rd.spin_i) * COUP_AW'(N_SPINS) + COUP_AW'(i_rd.spin_j));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_SPINS; k++) begin
                r_fld[k] <= '0;
            end
            r_coup_vld <= '0;
        end else begin
            if (i_wr.fld_we) begin
                r_fld[i_wr.spin_i] <= i_wr.data;
            end
            if (i_wr.coup_we) begin
                r_coup_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.coup_we) begin
            r_coup_mem[wr_addr] <= i_wr.data;
        end
        r_coup_q     <= r_coup_mem[rd_addr];
        r_coup_q_vld <= r_coup_vld[rd_addr];
        r_fld_q      <= r_fld[i_rd.spin_i];
        r_is_field   <= i_rd.is_field;
    end

    // An entry never written reads as zero
    always_comb begin
        if (r_is_field) begin
            o_rd_data = r_fld_q;
        end else if (r_coup_q_vld) begin
            o_rd_data = signed'(r_coup_q);
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

[rtl/ides_mac.sv]
// Shared signed multiplier with product register, rounding and 24-bit saturation.
// Depends on ides_pkg; rounding is to nearest, ties toward plus infinity.
module ides_mac
    import ides_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [MUL_W-1:0] i_op_a,
    input  logic signed [MUL_W-1:0] i_op_b,
    output logic signed [RES_W-1:0] o_rnd
);

    localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(1 << (FRAC_SH - 1));
    localparam logic signed [PROD_W-1:0] LIM_HI = PROD_W'((1 << (RES_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] LIM_LO = PROD_W'(-(1 << (RES_W - 1)));

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] shifted;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_op_a * i_op_b;
        end
    end

    assign biased  = r_prod + HALF;
    assign shifted = biased >>> FRAC_SH;

    always_comb begin
        if (shifted > LIM_HI) begin
            o_rnd = LIM_HI[RES_W-1:0];
        end else if (shifted < LIM_LO) begin
            o_rnd = LIM_LO[RES_W-1:0];
        end else begin
            o_rnd = shifted[RES_W-1:0];
        end
    end

endmodule

[rtl/ides_checker.sv]
// Port-level checker for the diagonal Ising energy block, bound to the top level.
// Depends on ides_pkg and ising_diagonal_energy_scale_assert.svh.
`include "ising_diagonal_energy_scale_assert.svh"

module ides_checker
    import ides_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_in_req  i_in_req,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_res o_out_res
);

    logic eval_fire;
    logic load_fire;

    assign eval_fire = i_in_valid && o_in_ready && (i_in_req.operation == OP_EVAL);
    assign load_fire = i_in_valid && o_in_ready && (i_in_req.operation != OP_EVAL);

    `IDES_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, eval_fire, !o_in_ready, "ready after evaluate")
    `IDES_ASSERT_NEXT(a_load_free, i_clk, i_rst_n, load_fire, o_in_ready, "busy after load")
    `IDES_ASSERT_IMPL(a_rise_after_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(!o_in_ready), "result without busy phase")
    `IDES_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_res), "stalled result changed")

endmodule

bind ising_diagonal_energy_scale ides_checker u_ides_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_res   (o_out_res)
);

[dv/tb_ising_diagonal_energy_scale.sv]
// Testbench of the diagonal Ising energy block: a directed request table, then random phases.
// Depends on ides_pkg and ising_diagonal_energy_scale. Results are checked against typed
// table values or an in-bench energy predictor with own coefficient tables and anneal scale.
module tb_ising_diagonal_energy_scale;
    timeunit 1ns;
    timeprecision 1ps;
    import ides_pkg::*;

    localparam int LATENCY_CYC  = 160;
    localparam int HOLD_CYC     = 1500;
    localparam int IDLE_PCT     = 37;
    localparam int PHASE_ITEMS  = 200;
    localparam int N_PHASES     = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_res res;
    } t_row;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    t_in_req            req = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    t_out_res           res;
    logic               cfg_we = 1'b0;
    logic [SCALE_W-1:0] cfg_wdata = SCALE_RESET;

    // predictor state
    shortint            h_field [N_SPINS];
    shortint            j_coup [N_SPINS][N_SPINS];
    logic [SCALE_W-1:0] anneal_s;
    t_out_res           energy_q[$];

    int err_cnt = 0;
    int results_seen = 0;
    bit idle_on = 1'b1;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ising_diagonal_energy_scale dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_req    (req),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_res   (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Round to nearest, ties up, then clamp to 24 bits.
    function automatic longint round_sat(longint x);
        longint y;
        y = (x + 64'sd16384) >>> 15;
        if (y > 64'sd8388607) begin
            y = 64'sd8388607;
        end else if (y < -64'sd8388608) begin
            y = -64'sd8388608;
        end
        return y;
    endfunction

    function automatic t_out_res ising_energy(t_in_req r);
        longint   sum, s, e, sre, sim;
        t_out_res o;
        sum = 0;
        for (int i = 0; i < N_SPINS; i++) begin
            if (r.basis_state[i]) begin
                sum += h_field[i];
            end else begin
                sum -= h_field[i];
            end
            for (int j = i + 1; j < N_SPINS; j++) begin
                if (r.basis_state[i] == r.basis_state[j]) begin
                    sum -= j_coup[i][j];
                end else begin
                    sum += j_coup[i][j];
                end
            end
        end
        s = anneal_s;
        e = round_sat(sum * s);
        sre = round_sat(longint'($signed(r.amp_re)) * e);
        sim = round_sat(longint'($signed(r.amp_im)) * e);
        o.energy    = e[RES_W-1:0];
        o.scaled_re = sre[RES_W-1:0];
        o.scaled_im = sim[RES_W-1:0];
        return o;
    endfunction

    task automatic ising_apply(input t_in_req r, input bit typed, input t_out_res typed_res);
        case (r.operation)
            OP_LOAD_FIELD: h_field[r.spin_i] = r.coefficient;
            OP_LOAD_COUP: begin
                if (r.spin_j > r.spin_i) begin
                    j_coup[r.spin_i][r.spin_j] = r.coefficient;
                end
            end
            OP_EVAL: energy_q.push_back(typed ? typed_res : ising_energy(r));
            default: ;
        endcase
    endtask

    task automatic send_item(input t_in_req r, input bit typed = 1'b0,
                             input t_out_res typed_res = '0);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        ising_apply(r, typed, typed_res);
    endtask

    // Hold off until every result is in and the block has gone quiet.
    task automatic drain();
        req_valid <= 1'b0;
        while (energy_q.size() != 0) @(posedge clk);
        repeat (LATENCY_CYC) @(posedge clk);
    endtask

    task automatic set_scale(input logic [SCALE_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        anneal_s  = v;
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_basis();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001 << $urandom_range(15);
            3: return ~(16'h0001 << $urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_req rand_req();
        t_in_req r;
        r.operation   = 2'($urandom);
        r.spin_i      = 4'($urandom);
        r.spin_j      = 4'($urandom);
        r.coefficient = pick16();
        r.basis_state = pick_basis();
        r.amp_re      = pick16();
        r.amp_im      = pick16();
        return r;
    endfunction

    task automatic send_mix(inout int cnt);
        t_in_req r;
        int      k;
        r = rand_req();
        k = $urandom_range(99);
        if (k < 30) begin
            r.operation = OP_LOAD_FIELD;
        end else if (k < 55) begin
            r.operation = OP_LOAD_COUP;
            r.spin_i    = 4'($urandom_range(14));
            r.spin_j    = 4'($urandom_range(15, r.spin_i + 1));
        end else if (k < 90) begin
            r.operation = OP_EVAL;
        end else if (k < 95) begin
            // pair not in upper triangle: dropped
            r.operation = OP_LOAD_COUP;
            r.spin_j    = 4'($urandom_range(r.spin_i));
        end else begin
            r.operation = OP_UNUSED;
        end
        send_item(r);
        if (k < 90) cnt++;
    endtask

    // Load every coefficient, mostly at aligned extremes so that all-ones states
    // drive the energy into saturation, then evaluate a few states.
    task automatic send_table_fill(input bit force_extreme, inout int cnt);
        t_in_req r;
        bit      pos, extreme;
        pos     = 1'($urandom_range(1));
        extreme = force_extreme || ($urandom_range(3) != 0);
        r = rand_req();
        for (int i = 0; i < N_SPINS; i++) begin
            r.operation   = OP_LOAD_FIELD;
            r.spin_i      = 4'(i);
            r.spin_j      = 4'($urandom);
            r.coefficient = extreme ? (pos ? 16'sh7FFF : 16'sh8000) : pick16();
            send_item(r);
            cnt++;
        end
        for (int i = 0; i < N_SPINS - 1; i++) begin
            for (int j = i + 1; j < N_SPINS; j++) begin
                r.operation   = OP_LOAD_COUP;
                r.spin_i      = 4'(i);
                r.spin_j      = 4'(j);
                r.coefficient = extreme ? (pos ? 16'sh8000 : 16'sh7FFF) : pick16();
                send_item(r);
                cnt++;
            end
        end
        repeat (8) begin
            r = rand_req();
            r.operation   = OP_EVAL;
            r.basis_state = $urandom_range(1) ? 16'hFFFF : pick_basis();
            send_item(r);
            cnt++;
        end
    endtask

    function automatic t_row mk_row(logic [1:0] op, logic [3:0] si, logic [3:0] sj,
                                    logic [15:0] coef, logic [15:0] basis,
                                    logic [15:0] are, logic [15:0] aim,
                                    bit typed = 1'b0, t_out_res res_v = '0);
        t_row row;
        row.req.operation   = op;
        row.req.spin_i      = si;
        row.req.spin_j      = sj;
        row.req.coefficient = coef;
        row.req.basis_state = basis;
        row.req.amp_re      = are;
        row.req.amp_im      = aim;
        row.typed           = typed;
        row.res             = res_v;
        return row;
    endfunction

    function automatic void check_field(string name, logic signed [RES_W-1:0] exp_v,
                                        logic signed [RES_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    always @(posedge clk) begin
        t_out_res exp_r;
        if (rst_n && res_valid && res_ready) begin
            results_seen++;
            if (energy_q.size() == 0) begin
                $display("%0t: result with no evaluate request pending, expected none, got %0d",
                         $time, res.energy);
                err_cnt++;
            end else begin
                exp_r = energy_q.pop_front();
                check_field("energy", exp_r.energy, res.energy);
                check_field("scaled_re", exp_r.scaled_re, res.scaled_re);
                check_field("scaled_im", exp_r.scaled_im, res.scaled_im);
            end
        end
    end

    // Receiver: random stalls, plus two long hold-offs so the block backs up.
    initial begin
        int       hold_left;
        bit [1:0] holds_done;
        hold_left  = 0;
        holds_done = '0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_left == 0 && !holds_done[0] && results_seen >= 30) begin
                hold_left     = HOLD_CYC;
                holds_done[0] = 1'b1;
            end
            if (hold_left == 0 && !holds_done[1] && results_seen >= 250) begin
                hold_left     = HOLD_CYC;
                holds_done[1] = 1'b1;
            end
            if (hold_left > 0) begin
                res_ready <= 1'b0;
                hold_left--;
            end else begin
                res_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        t_row               rows[$];
        int                 cnt;
        logic [SCALE_W-1:0] v;
        h_field  = '{default: 0};
        j_coup   = '{default: '{default: 0}};
        anneal_s = SCALE_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tables are zero after reset, so the first evaluations give zero
        rows.push_back(mk_row(OP_EVAL, 0, 0, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF,
                              1'b1, '0));
        rows.push_back(mk_row(OP_EVAL, 15, 15, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000,
                              1'b1, '0));
        rows.push_back(mk_row(OP_UNUSED, 0, 1, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000));
        rows.push_back(mk_row(OP_LOAD_FIELD, 0, 0, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000));
        rows.push_back(mk_row(OP_LOAD_FIELD, 15, 0, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        rows.push_back(mk_row(OP_EVAL, 0, 0, 16'h0000, 16'h0001, 16'h8000, 16'h7FFF));
        rows.push_back(mk_row(OP_EVAL, 0, 0, 16'h0000, 16'h8001, 16'h7FFF, 16'h8000));
        rows.push_back(mk_row(OP_LOAD_COUP, 0, 15, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000));
        rows.push_back(mk_row(OP_LOAD_COUP, 14, 15, 16'h8000, 16'h0000, 16'h0000, 16'h0000));
        rows.push_back(mk_row(OP_LOAD_COUP, 3, 3, 16'h1234, 16'h0000, 16'h0000, 16'h0000));
        rows.push_back(mk_row(OP_LOAD_COUP, 9, 2, 16'h4321, 16'h0000, 16'h0000, 16'h0000));
        rows.push_back(mk_row(OP_LOAD_COUP, 15, 0, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000));
        rows.push_back(mk_row(OP_LOAD_COUP, 0, 1, 16'h1000, 16'h0000, 16'h0000, 16'h0000));
        rows.push_back(mk_row(OP_EVAL, 0, 0, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000));
        rows.push_back(mk_row(OP_EVAL, 0, 0, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF));
        rows.push_back(mk_row(OP_EVAL, 0, 0, 16'h0000, 16'hAAAA, 16'h0000, 16'h0000));
        rows.push_back(mk_row(OP_EVAL, 0, 0, 16'h0000, 16'h5555, 16'h0001, 16'hFFFF));
        rows.push_back(mk_row(OP_UNUSED, 15, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        rows.push_back(mk_row(OP_LOAD_FIELD, 7, 0, 16'h0001, 16'h0000, 16'h0000, 16'h0000));
        rows.push_back(mk_row(OP_EVAL, 0, 0, 16'h0000, 16'h0080, 16'h4000, 16'hC000));
        rows.push_back(mk_row(OP_EVAL, 0, 0, 16'h0000, 16'h7FFF, 16'h8000, 16'h8000));
        foreach (rows[i]) send_item(rows[i].req, rows[i].typed, rows[i].res);

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: v = 16'd0;
                1: v = 16'hFFFF;
                2: v = 16'd1;
                3: v = 16'd32767;
                4: v = SCALE_RESET;
                6: v = 16'd16384;
                default: v = 16'($urandom);
            endcase
            set_scale(v);
            // one phase runs with no idling on either side
            idle_on = (p != 3);
            cnt = 0;
            if (p == 1 || p == 7) send_table_fill(p == 1, cnt);
            while (cnt < PHASE_ITEMS) send_mix(cnt);
        end
        idle_on = 1'b1;

        drain();
        if (err_cnt == 0) begin
            $display("tb_ising_diagonal_energy_scale passed");
        end else begin
            $display("tb_ising_diagonal_energy_scale failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_ising_diagonal_energy_scale failed");
        $finish;
    end

endmodule
